// File: sv/hdie_pkg.sv
`timescale 1ns / 1ps

package hdie_pkg;

   localparam int HDR_DATA_BITS  = 24;
   localparam int SUB_DATA_BITS  = 56;
   localparam int PARITY_BITS    = 8;
   localparam int SYMBOL_BITS    = 10;
   localparam int PIXEL_BITS     = 5;
   localparam int SUBPACKETS     = 4;
   localparam int SUB_DATA_PIXELS = SUB_DATA_BITS / 2;

   localparam logic [PARITY_BITS-1:0] BCH_POLY   = 8'h83;
   localparam logic [PIXEL_BITS-1:0]  PIXEL_LAST = 5'd31;
   localparam logic [PIXEL_BITS-1:0]  HDR_PARITY_PIXEL = PIXEL_BITS'(HDR_DATA_BITS);
   localparam logic [PIXEL_BITS-1:0]  SUB_PARITY_PIXEL = PIXEL_BITS'(SUB_DATA_PIXELS);

   typedef struct packed {
      logic [HDR_DATA_BITS-1:0] header_bytes;
      logic [SUB_DATA_BITS-1:0] subpacket_zero;
      logic [SUB_DATA_BITS-1:0] subpacket_one;
      logic [SUB_DATA_BITS-1:0] subpacket_two;
      logic [SUB_DATA_BITS-1:0] subpacket_three;
      logic                     hsync_level;
      logic                     vsync_level;
      logic                     first_in_island;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]  pixel_index;
      logic [SYMBOL_BITS-1:0] symbol_lane0;
      logic [SYMBOL_BITS-1:0] symbol_lane1;
      logic [SYMBOL_BITS-1:0] symbol_lane2;
      logic                   last_pixel;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       adv;
      logic       data_phase;
      logic [1:0] pair;
   } lane_ctl_type;

   function automatic logic [PARITY_BITS-1:0] bch_step(input logic [PARITY_BITS-1:0] state,
                                                       input logic                   bit_in);
      logic fb;
      fb = state[0] ^ bit_in;
      bch_step = (state >> 1) ^ (fb ? BCH_POLY : '0);
   endfunction

   function automatic logic [SYMBOL_BITS-1:0] terc4(input logic [3:0] nib);
      case (nib)
         4'h0: terc4 = 10'h29c;
         4'h1: terc4 = 10'h263;
         4'h2: terc4 = 10'h2e4;
         4'h3: terc4 = 10'h2e2;
         4'h4: terc4 = 10'h171;
         4'h5: terc4 = 10'h11e;
         4'h6: terc4 = 10'h18e;
         4'h7: terc4 = 10'h13c;
         4'h8: terc4 = 10'h2cc;
         4'h9: terc4 = 10'h139;
         4'ha: terc4 = 10'h19c;
         4'hb: terc4 = 10'h2c6;
         4'hc: terc4 = 10'h28e;
         4'hd: terc4 = 10'h271;
         4'he: terc4 = 10'h163;
         4'hf: terc4 = 10'h2c3;
         default: terc4 = 10'h29c;
      endcase
   endfunction

endpackage

// File: sv/hdie_sub_lane.sv
`timescale 1ns / 1ps

module hdie_sub_lane (
   input  logic                              clock,
   input  hdie_pkg::lane_ctl_type            ctl,
   input  logic [hdie_pkg::SUB_DATA_BITS-1:0] data,
   output logic [1:0]                        bits
);
   import hdie_pkg::*;

   logic [SUB_DATA_BITS-1:0] sr_ff, sr_in;
   logic [PARITY_BITS-1:0]   par_ff, par_in;

   always_comb begin
      sr_in  = sr_ff;
      par_in = par_ff;
      if (ctl.load) begin
         sr_in  = data;
         par_in = '0;
      end else if (ctl.adv) begin
         sr_in = sr_ff >> 2;
         if (ctl.data_phase) begin
            par_in = bch_step(bch_step(par_ff, sr_ff[0]), sr_ff[1]);
         end
      end
   end

   always_comb begin
      if (ctl.data_phase) begin
         bits = sr_ff[1:0];
      end else begin
         bits = {par_ff[{ctl.pair, 1'b1}], par_ff[{ctl.pair, 1'b0}]};
      end
   end

   always_ff @(posedge clock) begin
      sr_ff  <= sr_in;
      par_ff <= par_in;
   end

endmodule

// File: sv/hdmi_data_island_encoder_top.sv
`timescale 1ns / 1ps
// hdmi data-island encoder
// req channel: one data-island packet per transfer (header, four subpackets,
// hsync, vsync and the first-packet flag of the island)
// rsp channel: 32 transfers per packet, one per pixel in order 0..31, each
// with the three terc4 symbols, the pixel index and a last-pixel flag
// bch parity bytes are built serially by lfsrs while the data bits go out:
// header one bit per pixel, each subpacket two bits per pixel
// pixel 0 is built from the registers loaded by the packet transfer, then held in the output register
// the output takes one pixel per cycle while rsp_ready does not stall it;
// the next packet is taken in the cycle that pixel 31 moves to the output
// register, so packets follow each other with no gap
// reset clears the packet and output valid flags; no packet is held after it
// when rsp_ready is low the output register holds its pixel, the pixel
// counter stops, and req_ready stays low until the last pixel moves on
module hdmi_data_island_encoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdie_pkg::rsp_type rsp_data
);
   import hdie_pkg::*;

   logic                     busy_ff, busy_in;
   logic [PIXEL_BITS-1:0]    px_ff, px_in;
   logic [HDR_DATA_BITS-1:0] hdr_sr_ff, hdr_sr_in;
   logic [PARITY_BITS-1:0]   hdr_par_ff, hdr_par_in;
   logic                     hs_ff, vs_ff, first_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     adv, last, take, hdr_bit, started;
   lane_ctl_type             lane_ctl;
   logic [SUB_DATA_BITS-1:0] sub_data [SUBPACKETS];
   logic [1:0]               sub_bits [SUBPACKETS];
   logic [3:0]               nib1, nib2;

   assign adv       = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last      = (px_ff == PIXEL_LAST);
   assign req_ready = !busy_ff || (adv && last);
   assign take      = req_valid && req_ready;

   assign sub_data[0] = req_data.subpacket_zero;
   assign sub_data[1] = req_data.subpacket_one;
   assign sub_data[2] = req_data.subpacket_two;
   assign sub_data[3] = req_data.subpacket_three;

   assign lane_ctl.load       = take;
   assign lane_ctl.adv        = adv;
   assign lane_ctl.data_phase = (px_ff < SUB_PARITY_PIXEL);
   assign lane_ctl.pair       = px_ff[1:0];

   for (genvar s = 0; s < SUBPACKETS; s++) begin : g_lane
      hdie_sub_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .data  (sub_data[s]),
         .bits  (sub_bits[s])
      );
      assign nib1[s] = sub_bits[s][0];
      assign nib2[s] = sub_bits[s][1];
   end

   assign hdr_bit = (px_ff < HDR_PARITY_PIXEL) ? hdr_sr_ff[0] : hdr_par_ff[px_ff[2:0]];
   assign started = !((px_ff == '0) && first_ff);

   always_comb begin
      busy_in    = busy_ff;
      px_in      = px_ff;
      hdr_sr_in  = hdr_sr_ff;
      hdr_par_in = hdr_par_ff;
      if (adv) begin
         px_in     = px_ff + PIXEL_BITS'(1);
         hdr_sr_in = hdr_sr_ff >> 1;
         if (px_ff < HDR_PARITY_PIXEL) begin
            hdr_par_in = bch_step(hdr_par_ff, hdr_sr_ff[0]);
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         busy_in    = 1'b1;
         px_in      = '0;
         hdr_sr_in  = req_data.header_bytes;
         hdr_par_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (adv) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pixel_index  = px_ff;
         rsp_in.symbol_lane0 = terc4({hdr_bit, started, vs_ff, hs_ff});
         rsp_in.symbol_lane1 = terc4(nib1);
         rsp_in.symbol_lane2 = terc4(nib2);
         rsp_in.last_pixel   = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         px_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         px_ff        <= px_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_sr_ff  <= hdr_sr_in;
      hdr_par_ff <= hdr_par_in;
      rsp_ff     <= rsp_in;
      if (take) begin
         hs_ff    <= req_data.hsync_level;
         vs_ff    <= req_data.vsync_level;
         first_ff <= req_data.first_in_island;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
